// ----- rtl/core/sti_pkg.sv -----
// Package for the segment / triangle intersection pipeline.
// Request and response word types, point count and point slot indexes.
// No dependencies.
package sti_pkg;

   localparam int POINT_BITS = 48;
   localparam int NUM_POINTS = 5;
   localparam int NUM_AXES   = 3;

   localparam int PT_S = 0;
   localparam int PT_E = 1;
   localparam int PT_A = 2;
   localparam int PT_B = 3;
   localparam int PT_C = 4;

   localparam int AX_X = 0;
   localparam int AX_Y = 1;
   localparam int AX_Z = 2;

   typedef struct packed {
      logic [POINT_BITS-1:0] tri_c;
      logic [POINT_BITS-1:0] tri_b;
      logic [POINT_BITS-1:0] tri_a;
      logic [POINT_BITS-1:0] seg_end;
      logic [POINT_BITS-1:0] seg_start;
   } sti_req_type;

   typedef struct packed {
      logic hit;
      logic degenerate;
   } sti_rsp_type;

endpackage

// ----- rtl/core/segment_triangle_intersect.sv -----
// Segment / triangle intersection test, six register stages, exact integer math.
// A word accepted into stage 1 shows on rsp from the stage 6 register; one word per cycle while rsp_stall is low.
// Products come from combinational multipliers inside stages 2 and 3, one multiplier per product term.
// Stages hold valid bits and move independently, so bubbles close up under rsp_stall.
// Reset (synchronous, active high) clears all valid bits; payload registers are not reset.
// Depends on sti_pkg.
module segment_triangle_intersect #(
   parameter int COORD_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  sti_pkg::sti_req_type req_word,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output sti_pkg::sti_rsp_type rsp_word
);
   import sti_pkg::*;

   localparam int D  = COORD_BITS + 1;   // coordinate difference
   localparam int XW = 2 * D + 1;        // cross product component
   localparam int PW = D + XW;           // dot product term
   localparam int SW = PW + 2;           // dot product sum
   localparam int DW = SW + 1;           // determinant, nu + nv
   localparam int RW = DW + 1;           // d - (nu + nv)
   localparam int LW = (3 * COORD_BITS > POINT_BITS) ? 3 * COORD_BITS : POINT_BITS;

   // stage enables and valid bits
   logic en1, en2, en3, en4, en5, en6;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;

   assign en6 = !v6_ff || !rsp_stall;
   assign en5 = !v5_ff || en6;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_stall = !en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
         if (en6) v6_ff <= v5_ff;
      end
   end

   // lane unpack
   logic [LW-1:0]                pw  [NUM_POINTS];
   logic signed [COORD_BITS-1:0] crd [NUM_POINTS][NUM_AXES];

   always_comb begin
      pw[PT_S] = LW'(req_word.seg_start);
      pw[PT_E] = LW'(req_word.seg_end);
      pw[PT_A] = LW'(req_word.tri_a);
      pw[PT_B] = LW'(req_word.tri_b);
      pw[PT_C] = LW'(req_word.tri_c);
      for (int i = 0; i < NUM_POINTS; i++) begin
         for (int j = 0; j < NUM_AXES; j++) begin
            crd[i][j] = pw[i][j*COORD_BITS +: COORD_BITS];
         end
      end
   end

   // stage 1: edge vectors
   logic signed [D-1:0] ab_in [NUM_AXES], ac_in [NUM_AXES], rhs_in [NUM_AXES];
   logic signed [D-1:0] ea_in [NUM_AXES], se_in [NUM_AXES];
   logic signed [D-1:0] ab_ff [NUM_AXES], ac_ff [NUM_AXES], rhs_ff [NUM_AXES];
   logic signed [D-1:0] ea_ff [NUM_AXES], se_ff [NUM_AXES];

   always_comb begin
      for (int j = 0; j < NUM_AXES; j++) begin
         ab_in[j]  = crd[PT_B][j] - crd[PT_A][j];
         ac_in[j]  = crd[PT_C][j] - crd[PT_A][j];
         rhs_in[j] = crd[PT_S][j] - crd[PT_A][j];
         ea_in[j]  = crd[PT_E][j] - crd[PT_A][j];
         se_in[j]  = crd[PT_S][j] - crd[PT_E][j];
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         ab_ff  <= ab_in;
         ac_ff  <= ac_in;
         rhs_ff <= rhs_in;
         ea_ff  <= ea_in;
         se_ff  <= se_in;
      end
   end

   // stage 2: n = ab x ac, m1 = ac x se, m2 = ab x se
   logic signed [XW-1:0] n_in [NUM_AXES], m1_in [NUM_AXES], m2_in [NUM_AXES];
   logic signed [XW-1:0] n_ff [NUM_AXES], m1_ff [NUM_AXES], m2_ff [NUM_AXES];
   logic signed [D-1:0]  rhs2_ff [NUM_AXES], ea2_ff [NUM_AXES];

   always_comb begin
      n_in[AX_X]  = ab_ff[AX_Y] * ac_ff[AX_Z] - ab_ff[AX_Z] * ac_ff[AX_Y];
      n_in[AX_Y]  = ab_ff[AX_Z] * ac_ff[AX_X] - ab_ff[AX_X] * ac_ff[AX_Z];
      n_in[AX_Z]  = ab_ff[AX_X] * ac_ff[AX_Y] - ab_ff[AX_Y] * ac_ff[AX_X];
      m1_in[AX_X] = ac_ff[AX_Y] * se_ff[AX_Z] - ac_ff[AX_Z] * se_ff[AX_Y];
      m1_in[AX_Y] = ac_ff[AX_Z] * se_ff[AX_X] - ac_ff[AX_X] * se_ff[AX_Z];
      m1_in[AX_Z] = ac_ff[AX_X] * se_ff[AX_Y] - ac_ff[AX_Y] * se_ff[AX_X];
      m2_in[AX_X] = ab_ff[AX_Y] * se_ff[AX_Z] - ab_ff[AX_Z] * se_ff[AX_Y];
      m2_in[AX_Y] = ab_ff[AX_Z] * se_ff[AX_X] - ab_ff[AX_X] * se_ff[AX_Z];
      m2_in[AX_Z] = ab_ff[AX_X] * se_ff[AX_Y] - ab_ff[AX_Y] * se_ff[AX_X];
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         n_ff    <= n_in;
         m1_ff   <= m1_in;
         m2_ff   <= m2_in;
         rhs2_ff <= rhs_ff;
         ea2_ff  <= ea_ff;
      end
   end

   // stage 3: dot product terms
   logic signed [PW-1:0] pt_in [NUM_AXES], pq_in [NUM_AXES];
   logic signed [PW-1:0] pu_in [NUM_AXES], pv_in [NUM_AXES];
   logic signed [PW-1:0] pt_ff [NUM_AXES], pq_ff [NUM_AXES];
   logic signed [PW-1:0] pu_ff [NUM_AXES], pv_ff [NUM_AXES];

   always_comb begin
      for (int j = 0; j < NUM_AXES; j++) begin
         pt_in[j] = rhs2_ff[j] * n_ff[j];
         pq_in[j] = ea2_ff[j] * n_ff[j];
         pu_in[j] = rhs2_ff[j] * m1_ff[j];
         pv_in[j] = rhs2_ff[j] * m2_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         pt_ff <= pt_in;
         pq_ff <= pq_in;
         pu_ff <= pu_in;
         pv_ff <= pv_in;
      end
   end

   // stage 4: nt = rhs.n, q = ea.n, nu, nv
   logic signed [SW-1:0] nt_in, q_in, nu_in, nv_in;
   logic signed [SW-1:0] nt_ff, q_ff, nu_ff, nv_ff;

   always_comb begin
      nt_in = pt_ff[AX_X] + pt_ff[AX_Y] + pt_ff[AX_Z];
      q_in  = pq_ff[AX_X] + pq_ff[AX_Y] + pq_ff[AX_Z];
      nu_in = pu_ff[AX_X] + pu_ff[AX_Y] + pu_ff[AX_Z];
      nv_in = -(pv_ff[AX_X] + pv_ff[AX_Y] + pv_ff[AX_Z]);
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         nt_ff <= nt_in;
         q_ff  <= q_in;
         nu_ff <= nu_in;
         nv_ff <= nv_in;
      end
   end

   // stage 5: determinant d = nt - q, nu + nv, sign flags
   logic signed [DW-1:0] d_in, uv_in;
   logic signed [DW-1:0] d_ff, uv_ff;
   logic nt_neg_ff, nt_zero_ff, q_neg_ff, q_zero_ff;
   logic nu_neg_ff, nu_zero_ff, nv_neg_ff, nv_zero_ff;

   always_comb begin
      d_in  = nt_ff - q_ff;
      uv_in = nu_ff + nv_ff;
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         d_ff       <= d_in;
         uv_ff      <= uv_in;
         nt_neg_ff  <= nt_ff[SW-1];
         nt_zero_ff <= (nt_ff == '0);
         q_neg_ff   <= q_ff[SW-1];
         q_zero_ff  <= (q_ff == '0);
         nu_neg_ff  <= nu_ff[SW-1];
         nu_zero_ff <= (nu_ff == '0);
         nv_neg_ff  <= nv_ff[SW-1];
         nv_zero_ff <= (nv_ff == '0);
      end
   end

   // stage 6: bounds check into the output register
   logic signed [RW-1:0] r_val;
   logic d_neg, d_zero, r_neg, r_zero, same_side;
   logic pos_ok, neg_ok;
   sti_rsp_type rsp_in, rsp_ff;

   always_comb begin
      r_val     = d_ff - uv_ff;
      d_neg     = d_ff[DW-1];
      d_zero    = (d_ff == '0);
      r_neg     = r_val[RW-1];
      r_zero    = (r_val == '0);
      same_side = !nt_zero_ff && !q_zero_ff && (nt_neg_ff == q_neg_ff);
      // d > 0: nu, nv, d-nu-nv, nt >= 0 and q <= 0
      pos_ok    = !nu_neg_ff && !nv_neg_ff && !r_neg && !nt_neg_ff
                  && (q_neg_ff || q_zero_ff);
      // d < 0: every bound flips
      neg_ok    = (nu_neg_ff || nu_zero_ff) && (nv_neg_ff || nv_zero_ff)
                  && (r_neg || r_zero) && (nt_neg_ff || nt_zero_ff) && !q_neg_ff;
      rsp_in.degenerate = !same_side && d_zero;
      rsp_in.hit        = !same_side && !d_zero && (d_neg ? neg_ok : pos_ok);
   end

   always_ff @(posedge clock) begin
      if (en6) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = v6_ff;
   assign rsp_word  = rsp_ff;

   a_excl: assert property (@(posedge clock) disable iff (reset)
      v6_ff |-> !(rsp_ff.hit && rsp_ff.degenerate))
      else $error("hit and degenerate both set");

   a_empty_front: assert property (@(posedge clock) disable iff (reset)
      !v1_ff |-> !req_stall)
      else $error("stall raised with empty first stage");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      v5_ff && en6 |=> v6_ff)
      else $error("word lost between last two stages");

   a_reset: assert property (@(posedge clock)
      reset |=> !v6_ff && !v1_ff)
      else $error("valid survives reset");

endmodule

// ----- tb/sv/tb_segment_triangle_intersect.sv -----
// Testbench for segment_triangle_intersect: a directed table, then random segment / triangle
// words, checked against an exact integer predictor under several idle and stall patterns.
// Depends on sti_pkg and the segment_triangle_intersect RTL.
module tb_segment_triangle_intersect;
   import sti_pkg::*;

   localparam int COORD_BITS   = 16;
   localparam int RANDOM_WORDS = 1248;
   localparam int NUM_PHASES   = 4;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 400;
   localparam int SEND_IDLE_PCT [NUM_PHASES] = '{0, 64, 0, 18};
   localparam int STALL_PCT     [NUM_PHASES] = '{0, 0, 64, 18};

   localparam sti_rsp_type MISS_VERDICT  = '{hit: 1'b0, degenerate: 1'b0};
   localparam sti_rsp_type DEGEN_VERDICT = '{hit: 1'b0, degenerate: 1'b1};

   typedef logic signed [127:0] exact_type;

   typedef struct packed {
      sti_req_type word;
      logic        known;
      sti_rsp_type verdict;
   } probe_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   sti_req_type req_word;
   logic        rsp_valid;
   logic        rsp_stall;
   sti_rsp_type rsp_word;

   sti_rsp_type pending_verdicts [$];
   probe_type   probes [$];
   int          n_errors      = 0;
   int          send_idle_pct = 0;
   int          stall_pct     = 0;
   int          hold_off      = 0;
   int          cycle_count   = 0;

   segment_triangle_intersect #(
      .COORD_BITS(COORD_BITS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic exact_type coord(input logic [POINT_BITS-1:0] p, input int ax);
      logic [COORD_BITS-1:0] raw;
      raw = p[ax*COORD_BITS +: COORD_BITS];
      return {{(128-COORD_BITS){raw[COORD_BITS-1]}}, raw};
   endfunction

   // determinant of the 3x3 matrix with columns p, q, w
   function automatic exact_type det3(input exact_type p [NUM_AXES],
                                      input exact_type q [NUM_AXES],
                                      input exact_type w [NUM_AXES]);
      return p[AX_X] * (q[AX_Y] * w[AX_Z] - q[AX_Z] * w[AX_Y])
           - p[AX_Y] * (q[AX_X] * w[AX_Z] - q[AX_Z] * w[AX_X])
           + p[AX_Z] * (q[AX_X] * w[AX_Y] - q[AX_Y] * w[AX_X]);
   endfunction

   function automatic sti_rsp_type crossing_verdict(input sti_req_type w);
      logic [NUM_POINTS*POINT_BITS-1:0] flat;
      exact_type pnt [NUM_POINTS][NUM_AXES];
      exact_type ab [NUM_AXES], ac [NUM_AXES], se [NUM_AXES], sa [NUM_AXES], ea [NUM_AXES];
      exact_type o1, o2, d, nu, nv, nt;
      sti_rsp_type r;
      flat = w;
      r = MISS_VERDICT;
      for (int k = 0; k < NUM_POINTS; k++)
         for (int ax = 0; ax < NUM_AXES; ax++)
            pnt[k][ax] = coord(flat[k*POINT_BITS +: POINT_BITS], ax);
      for (int ax = 0; ax < NUM_AXES; ax++) begin
         ab[ax] = pnt[PT_B][ax] - pnt[PT_A][ax];
         ac[ax] = pnt[PT_C][ax] - pnt[PT_A][ax];
         se[ax] = pnt[PT_S][ax] - pnt[PT_E][ax];
         sa[ax] = pnt[PT_S][ax] - pnt[PT_A][ax];
         ea[ax] = pnt[PT_E][ax] - pnt[PT_A][ax];
      end
      o1 = det3(ab, ac, sa);
      o2 = det3(ab, ac, ea);
      if (!(o1 != 0 && o2 != 0 && ((o1 < 0) == (o2 < 0)))) begin
         d = det3(ab, ac, se);
         if (d == 0) begin
            r.degenerate = 1'b1;
         end else begin
            nu = det3(sa, ac, se);
            nv = det3(ab, sa, se);
            nt = det3(ab, ac, sa);
            if (d < 0) begin
               d  = -d;
               nu = -nu;
               nv = -nv;
               nt = -nt;
            end
            r.hit = (nu >= 0) && (nv >= 0) && (d - nu - nv >= 0) && (nt >= 0) && (d - nt >= 0);
         end
      end
      return r;
   endfunction

   function automatic logic [POINT_BITS-1:0] pt3(input int x, input int y, input int z);
      logic [POINT_BITS-1:0] r;
      r = '0;
      r[AX_X*COORD_BITS +: COORD_BITS] = x[COORD_BITS-1:0];
      r[AX_Y*COORD_BITS +: COORD_BITS] = y[COORD_BITS-1:0];
      r[AX_Z*COORD_BITS +: COORD_BITS] = z[COORD_BITS-1:0];
      return r;
   endfunction

   function automatic sti_req_type mk_req(input logic [POINT_BITS-1:0] s, e, a, b, c);
      sti_req_type r;
      r.seg_start = s;
      r.seg_end   = e;
      r.tri_a     = a;
      r.tri_b     = b;
      r.tri_c     = c;
      return r;
   endfunction

   function automatic int rnd_signed(input int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic int extreme_coord();
      case ($urandom_range(0, 4))
         0: return -32768;
         1: return 32767;
         2: return 0;
         3: return -1;
         default: return rnd_signed(32767);
      endcase
   endfunction

   function automatic logic [POINT_BITS-1:0] rand48();
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      return r[POINT_BITS-1:0];
   endfunction

   // mostly planted crossings and boundary touches, then degenerate shapes, extremes, noise
   function automatic sti_req_type random_word();
      int a [3], b [3], c [3], s [3], e [3], p [3], dir [3];
      int span, kind, wa, wb, wc, m1, m2, pick, j1, j2;
      sti_req_type w;
      kind = $urandom_range(0, 99);
      span = (1 << $urandom_range(2, 12)) - 1;
      wa = $urandom_range(0, 8);
      wb = $urandom_range(0, 8);
      wc = $urandom_range(0, 8);
      if (wa + wb + wc == 0) wa = 1;
      m1 = $urandom_range(0, 3);
      m2 = $urandom_range(0, 3);
      pick = $urandom_range(0, 4);
      j1 = $urandom_range(0, 2) - 1;
      j2 = $urandom_range(0, 2) - 1;
      for (int i = 0; i < 3; i++) begin
         a[i]   = rnd_signed(span);
         b[i]   = rnd_signed(span);
         c[i]   = rnd_signed(span);
         dir[i] = rnd_signed(span);
         s[i]   = rnd_signed(span);
         e[i]   = rnd_signed(span);
      end
      if (kind < 50) begin
         for (int i = 0; i < 3; i++) begin
            p[i] = (wa * a[i] + wb * b[i] + wc * c[i]) / (wa + wb + wc);
            s[i] = p[i] + m1 * dir[i];
            e[i] = p[i] - m2 * dir[i];
         end
      end else if (kind < 62) begin
         for (int i = 0; i < 3; i++) begin
            a[i] = a[i] & ~1;
            b[i] = b[i] & ~1;
            c[i] = c[i] & ~1;
            case (pick)
               0: p[i] = a[i];
               1: p[i] = b[i];
               2: p[i] = c[i];
               3: p[i] = (a[i] + b[i]) / 2;
               default: p[i] = (b[i] + c[i]) / 2;
            endcase
            s[i] = p[i];
            e[i] = p[i] + (m1 + 1) * dir[i];
         end
         if (m2[0]) begin
            p = s;
            s = e;
            e = p;
         end
      end else if (kind < 72) begin
         for (int i = 0; i < 3; i++) begin
            case (pick)
               0: c[i] = a[i] + 2 * (b[i] - a[i]);
               1: b[i] = a[i];
               2: e[i] = s[i] + j1 * (b[i] - a[i]) + j2 * (c[i] - a[i]);
               default: begin
                  s[i] = a[i];
                  e[i] = b[i] + c[i] - a[i];
               end
            endcase
         end
      end else if (kind < 86) begin
         for (int i = 0; i < 3; i++) begin
            a[i] = extreme_coord();
            b[i] = extreme_coord();
            c[i] = extreme_coord();
            s[i] = extreme_coord();
            e[i] = extreme_coord();
         end
      end
      if (kind < 86) begin
         w = mk_req(pt3(s[0], s[1], s[2]), pt3(e[0], e[1], e[2]), pt3(a[0], a[1], a[2]),
                    pt3(b[0], b[1], b[2]), pt3(c[0], c[1], c[2]));
      end else begin
         w = mk_req(rand48(), rand48(), rand48(), rand48(), rand48());
      end
      return w;
   endfunction

   task automatic add_probe(input sti_req_type w, input logic known, input sti_rsp_type v);
      probe_type row;
      row.word    = w;
      row.known   = known;
      row.verdict = v;
      probes.insert(probes.size(), row);
   endtask

   task automatic drive_word(input sti_req_type w, input sti_rsp_type want);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      pending_verdicts.insert(pending_verdicts.size(), want);
   endtask

   initial begin : rsp_side
      sti_rsp_type want;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_verdicts.size() == 0) begin
               $error("response word with no request pending");
               n_errors++;
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_word.hit !== want.hit) begin
                  $error("hit: expected %0b, got %0b", want.hit, rsp_word.hit);
                  n_errors++;
               end
               if (rsp_word.degenerate !== want.degenerate) begin
                  $error("degenerate: expected %0b, got %0b", want.degenerate,
                         rsp_word.degenerate);
                  n_errors++;
               end
            end
         end
         if (hold_off > 0) begin
            rsp_stall <= 1'b1;
            hold_off--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   initial begin : sequencer
      logic [POINT_BITS-1:0] ta, tb, tc, ea, eb, ec;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_word  <= '0;
      ta = pt3(0, 0, 0);
      tb = pt3(100, 0, 0);
      tc = pt3(0, 100, 0);
      ea = pt3(-32768, -32768, 0);
      eb = pt3(32767, -32768, 0);
      ec = pt3(-32768, 32767, 0);

      add_probe('0, 1'b1, DEGEN_VERDICT);
      add_probe('1, 1'b1, DEGEN_VERDICT);
      add_probe(mk_req(pt3(10, 10, -10), pt3(10, 10, 10), ta, tb, tc), 1'b0, MISS_VERDICT);
      add_probe(mk_req(pt3(10, 10, -10), pt3(10, 10, 10), ta, tc, tb), 1'b0, MISS_VERDICT);
      add_probe(mk_req(pt3(10, 10, 10), pt3(10, 10, -10), ta, tb, tc), 1'b0, MISS_VERDICT);
      add_probe(mk_req(pt3(0, 0, -5), pt3(0, 0, 5), ta, tb, tc), 1'b0, MISS_VERDICT);
      add_probe(mk_req(pt3(50, 50, -1), pt3(50, 50, 1), ta, tb, tc), 1'b0, MISS_VERDICT);
      add_probe(mk_req(pt3(51, 50, -1), pt3(51, 50, 1), ta, tb, tc), 1'b0, MISS_VERDICT);
      add_probe(mk_req(pt3(10, 10, 0), pt3(10, 10, 10), ta, tb, tc), 1'b0, MISS_VERDICT);
      add_probe(mk_req(pt3(10, 10, 10), pt3(10, 10, 0), ta, tb, tc), 1'b0, MISS_VERDICT);
      add_probe(mk_req(pt3(200, 10, 0), pt3(200, 10, 10), ta, tb, tc), 1'b0, MISS_VERDICT);
      add_probe(mk_req(pt3(10, 10, -10), pt3(10, 10, -1), ta, tb, tc), 1'b0, MISS_VERDICT);
      add_probe(mk_req(pt3(1000, 1000, -5), pt3(1000, 1000, 5), ta, tb, tc), 1'b0,
                MISS_VERDICT);
      add_probe(mk_req(pt3(10, 10, 5), pt3(20, 20, 5), ta, tb, tc), 1'b1, MISS_VERDICT);
      add_probe(mk_req(pt3(10, 10, 0), pt3(20, 20, 0), ta, tb, tc), 1'b1, DEGEN_VERDICT);
      add_probe(mk_req(pt3(10, 10, 0), pt3(10, 10, 0), ta, tb, tc), 1'b1, DEGEN_VERDICT);
      add_probe(mk_req(pt3(10, 10, 7), pt3(10, 10, 7), ta, tb, tc), 1'b1, MISS_VERDICT);
      add_probe(mk_req(pt3(0, 5, -3), pt3(1, -4, 7), pt3(0, 0, 0), pt3(10, 10, 10),
                       pt3(20, 20, 20)), 1'b1, DEGEN_VERDICT);
      add_probe(mk_req(pt3(0, 5, -3), pt3(1, -4, 7), pt3(5, 5, 5), pt3(5, 5, 5),
                       pt3(9, 1, 3)), 1'b1, DEGEN_VERDICT);
      add_probe(mk_req(pt3(-32768, -32768, -32768), pt3(-32768, -32768, 32767), ea, eb, ec),
                1'b0, MISS_VERDICT);
      add_probe(mk_req(pt3(-1, -1, -32768), pt3(-1, -1, 32767), ea, eb, ec), 1'b0,
                MISS_VERDICT);
      add_probe(mk_req(pt3(0, 0, 32767), pt3(0, 0, -32768), ea, ec, eb), 1'b0, MISS_VERDICT);
      add_probe(mk_req(pt3(-32768, -32768, 32767), pt3(32767, 32767, -32768),
                       pt3(32767, 32767, 32767), pt3(-32768, 32767, -32768),
                       pt3(32767, -32768, -32768)), 1'b0, MISS_VERDICT);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (probes[i])
         drive_word(probes[i].word,
                    probes[i].known ? probes[i].verdict : crossing_verdict(probes[i].word));

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         send_idle_pct = SEND_IDLE_PCT[ph];
         stall_pct     = STALL_PCT[ph];
         if (ph == 0) hold_off = HOLD_CYCLES;
         for (int i = 0; i < RANDOM_WORDS / NUM_PHASES; i++) begin
            sti_req_type w;
            w = random_word();
            drive_word(w, crossing_verdict(w));
         end
      end
      req_valid <= 1'b0;

      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (n_errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/sti_pkg.sv
rtl/core/segment_triangle_intersect.sv
tb/sv/tb_segment_triangle_intersect.sv
